[src/pfa_pkg.sv]
package pfa_pkg;

	// field modulus and derived constants
	localparam logic [29:0] P_MOD     = 30'd1000000007;
	localparam logic [31:0] P_MOD_X2  = 32'd2000000014;
	// floor(2^60 / p) for the barrett quotient estimate
	localparam logic [30:0] BARRETT_M = 31'd1152921496;
	// fermat exponent p - 2 for the inverse
	localparam logic [62:0] EXP_INV   = 63'd1000000005;
	localparam logic [5:0]  EXP_MSB   = 6'd62;

	typedef enum logic [2:0] {
		K_ADD = 3'd0,
		K_SUB = 3'd1,
		K_MUL = 3'd2,
		K_POW = 3'd3,
		K_DIV = 3'd4
	} kind_t;

	// operand pairs for the shared modular multiplier
	typedef enum logic [1:0] {
		SEL_AB    = 2'd0,
		SEL_SQR   = 2'd1,
		SEL_BASE  = 2'd2,
		SEL_FINAL = 2'd3
	} mm_sel_t;

	// source of the result register
	typedef enum logic [2:0] {
		RES_ZERO = 3'd0,
		RES_ERR  = 3'd1,
		RES_ADD  = 3'd2,
		RES_SUB  = 3'd3,
		RES_ACC  = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     mm_start;
		mm_sel_t  mm_sel;
		logic     acc_init;
		logic     exp_shift;
		logic     res_write;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  err;
		logic  mm_done;
		logic  exp_bit;
	} sts_t;

endpackage

[src/pfa_modmul.sv]
module pfa_modmul import pfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [29:0] x,
	input  logic [29:0] y,
	output logic        done,
	output logic [29:0] res
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [59:0] prod_s1;
	logic [61:0] t_s2;
	logic [31:0] lo_s2, lo_s3;
	logic [31:0] qp_s3;
	logic [29:0] res_s4;
	logic [31:0] r;
	logic [30:0] q;

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// quotient estimate and remainder before correction
	assign q = t_s2[61:31];
	assign r = lo_s3 - qp_s3;

	// full product, barrett estimate, q*p, then final correction
	always_ff @(posedge clk) begin
		prod_s1 <= 60'(x) * 60'(y);
		t_s2    <= 62'(prod_s1[59:29]) * 62'(BARRETT_M);
		lo_s2   <= prod_s1[31:0];
		qp_s3   <= 32'(q) * 32'(P_MOD);
		lo_s3   <= lo_s2;
		if (r >= P_MOD_X2) begin
			res_s4 <= 30'(r - P_MOD_X2);
		end else if (r >= 32'(P_MOD)) begin
			res_s4 <= 30'(r - 32'(P_MOD));
		end else begin
			res_s4 <= r[29:0];
		end
	end

	assign done = v_s4;
	assign res  = res_s4;

endmodule

[src/pfa_datapath.sv]
module pfa_datapath import pfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [2:0]  kind,
	input  logic [29:0] operand_a,
	input  logic [62:0] operand_b,
	output logic [29:0] value,
	output logic        range_error
);

	kind_t       kind_q;
	logic        err_q;
	logic [29:0] a_q, b_q, base_q, acc_q;
	logic [62:0] exp_q;
	logic [29:0] value_q;
	logic        range_error_q;
	logic [29:0] mm_x, mm_y, mm_res, acc_cur;
	logic        mm_done;
	kind_t       kind_in;
	logic        b_reduced, kind_ok, err_in;
	logic [30:0] sum, diff;

	// operand range check on the incoming request
	assign kind_in   = kind_t'(kind);
	assign b_reduced = (kind_in == K_ADD) || (kind_in == K_SUB) ||
	                   (kind_in == K_MUL) || (kind_in == K_DIV);
	assign kind_ok   = b_reduced || (kind_in == K_POW);
	assign err_in    = kind_ok && ((operand_a >= P_MOD) ||
	                   (b_reduced && (operand_b >= 63'(P_MOD))));

	// request capture, accumulator and exponent shifter
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_in;
			err_q  <= err_in;
			a_q    <= operand_a;
			b_q    <= operand_b[29:0];
			if (kind_in == K_DIV) begin
				base_q <= operand_b[29:0];
				exp_q  <= EXP_INV;
			end else begin
				base_q <= operand_a;
				exp_q  <= operand_b;
			end
		end else if (cmd.exp_shift) begin
			exp_q <= {exp_q[61:0], 1'b0};
		end
		if (cmd.acc_init) begin
			acc_q <= 30'd1;
		end else if (mm_done) begin
			acc_q <= mm_res;
		end
	end

	// multiplier result bypasses the accumulator in its done cycle
	assign acc_cur = mm_done ? mm_res : acc_q;

	// multiplier operand select
	always_comb begin
		case (cmd.mm_sel)
			SEL_AB: begin
				mm_x = a_q;
				mm_y = b_q;
			end
			SEL_SQR: begin
				mm_x = acc_cur;
				mm_y = acc_cur;
			end
			SEL_BASE: begin
				mm_x = acc_cur;
				mm_y = base_q;
			end
			SEL_FINAL: begin
				mm_x = a_q;
				mm_y = acc_cur;
			end
			default: begin
				mm_x = a_q;
				mm_y = b_q;
			end
		endcase
	end

	pfa_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mm_start),
		.x      (mm_x),
		.y      (mm_y),
		.done   (mm_done),
		.res    (mm_res)
	);

	// add and subtract with one correction step
	assign sum  = 31'(a_q) + 31'(b_q);
	assign diff = (a_q >= b_q) ? 31'(a_q - b_q) : 31'(a_q) + 31'(P_MOD) - 31'(b_q);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_write) begin
			case (cmd.res_sel)
				RES_ERR: begin
					value_q       <= '0;
					range_error_q <= 1'b1;
				end
				RES_ADD: begin
					value_q       <= (sum >= 31'(P_MOD)) ? 30'(sum - 31'(P_MOD)) : sum[29:0];
					range_error_q <= 1'b0;
				end
				RES_SUB: begin
					value_q       <= diff[29:0];
					range_error_q <= 1'b0;
				end
				RES_ACC: begin
					value_q       <= acc_q;
					range_error_q <= 1'b0;
				end
				default: begin
					value_q       <= '0;
					range_error_q <= 1'b0;
				end
			endcase
		end
	end

	assign value       = value_q;
	assign range_error = range_error_q;

	assign sts.kind    = kind_q;
	assign sts.err     = err_q;
	assign sts.mm_done = mm_done;
	assign sts.exp_bit = exp_q[62];

endmodule

[src/pfa_ctrl.sv]
module pfa_ctrl import pfa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE       = 7'b0000001,
		ST_DECODE     = 7'b0000010,
		ST_SQR        = 7'b0000100,
		ST_SQR_WAIT   = 7'b0001000,
		ST_MUL_WAIT   = 7'b0010000,
		ST_FINAL_WAIT = 7'b0100000,
		ST_WRITE      = 7'b1000000
	} state_t;

	state_t   state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	res_sel_t res_sel_q, res_sel_d;
	logic     out_valid_q;
	logic     advance;
	logic     out_free;

	assign out_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		res_sel_d     = res_sel_q;
		advance       = 1'b0;
		cmd           = '0;
		cmd.mm_sel    = SEL_AB;
		cmd.res_sel   = res_sel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.err) begin
					res_sel_d = RES_ERR;
					state_d   = ST_WRITE;
				end else begin
					case (sts.kind)
						K_ADD: begin
							res_sel_d = RES_ADD;
							state_d   = ST_WRITE;
						end
						K_SUB: begin
							res_sel_d = RES_SUB;
							state_d   = ST_WRITE;
						end
						K_MUL: begin
							cmd.mm_start = 1'b1;
							cmd.mm_sel   = SEL_AB;
							state_d      = ST_FINAL_WAIT;
						end
						K_POW, K_DIV: begin
							cmd.acc_init = 1'b1;
							cnt_d        = EXP_MSB;
							state_d      = ST_SQR;
						end
						default: begin
							res_sel_d = RES_ZERO;
							state_d   = ST_WRITE;
						end
					endcase
				end
			end
			ST_SQR: begin
				cmd.mm_start = 1'b1;
				cmd.mm_sel   = SEL_SQR;
				state_d      = ST_SQR_WAIT;
			end
			ST_SQR_WAIT: begin
				if (sts.mm_done) begin
					if (sts.exp_bit) begin
						cmd.mm_start = 1'b1;
						cmd.mm_sel   = SEL_BASE;
						state_d      = ST_MUL_WAIT;
					end else begin
						advance = 1'b1;
					end
				end
			end
			ST_MUL_WAIT: begin
				if (sts.mm_done) begin
					advance = 1'b1;
				end
			end
			ST_FINAL_WAIT: begin
				if (sts.mm_done) begin
					res_sel_d = RES_ACC;
					state_d   = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					cmd.res_write = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// move to the next exponent bit or finish the power
		if (advance) begin
			if (cnt_q == '0) begin
				if (sts.kind == K_DIV) begin
					cmd.mm_start = 1'b1;
					cmd.mm_sel   = SEL_FINAL;
					state_d      = ST_FINAL_WAIT;
				end else begin
					res_sel_d = RES_ACC;
					state_d   = ST_WRITE;
				end
			end else begin
				cnt_d         = cnt_q - 6'd1;
				cmd.exp_shift = 1'b1;
				cmd.mm_start  = 1'b1;
				cmd.mm_sel    = SEL_SQR;
				state_d       = ST_SQR_WAIT;
			end
		end
	end

	// state, bit counter, result select and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_sel_q   <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			res_sel_q <= res_sel_d;
			if (cmd.res_write) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[src/prime_field_arith_unit.sv]
// add and subtract write their result directly after decode, multiply runs one modular multiply,
// power squares once per exponent bit (63 bits) and multiplies by the base on each set bit,
// divide runs the same loop on the exponent p-2 (15 set bits) plus one final multiply by a;
// every modular multiply runs on the single shared barrett multiplier, one at a time;
// in_ready rises in the same cycle as out_valid, once the previous result has moved to the
// output register; arst_n clears the controller, the multiplier valid pipe and output valid
module prime_field_arith_unit import pfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [29:0] operand_a,
	input  logic [62:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [29:0] value,
	output logic        range_error
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// operand, accumulator and result datapath
	pfa_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.value       (value),
		.range_error (range_error)
	);

`ifndef SYNTHESIS
	// in_ready drops once a request has been taken
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous one still decoding");

	// an error result carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> value == '0)
		else $error("range error with nonzero value");

	// every result is reduced
	a_value_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> value < P_MOD)
		else $error("result not reduced modulo p");
`endif

endmodule
